FILE: hdl/ltd_pkg.sv
// Shared widths and types for the LZ77 token decoder.
// Used by ltd_hist_ram, ltd_token_check and lz77_token_decoder; depends on nothing.
package ltd_pkg;

   // Fixed field widths of the token and output byte.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int DIST_W = 13;

   // Verdict on an incoming match token.
   typedef struct packed {
      logic             drop;
      logic [LEN_W-1:0] len;
   } tok_chk_type;

endpackage

FILE: hdl/ltd_hist_ram.sv
// History memory of the LZ77 token decoder: one write port, one registered read port.
// Depends on ltd_pkg for the byte width.
module ltd_hist_ram
   import ltd_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data_ff
);

   logic [BYTE_W-1:0] hist_mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered; a read at the address being written returns the old byte.
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
   end

endmodule

FILE: hdl/ltd_token_check.sv
// Validity check and length clamp for a match token of the LZ77 token decoder.
// Depends on ltd_pkg for field widths and the verdict struct.
module ltd_token_check
   import ltd_pkg::*;
#(
   parameter int MAX_LEN = 32,
   parameter int CNT_W   = 13
) (
   input  logic [LEN_W-1:0]  match_length,
   input  logic [DIST_W-1:0] match_distance,
   input  logic [CNT_W-1:0]  bytes_written,
   output tok_chk_type       verdict
);

   localparam int CMP_W = (DIST_W > CNT_W) ? DIST_W : CNT_W;

   logic too_far;
   logic too_long;

   // A distance past the written history cannot be served.
   assign too_far  = CMP_W'(match_distance) > CMP_W'(bytes_written);
   assign too_long = (LEN_W+1)'(match_length) > (LEN_W+1)'(MAX_LEN);

   // Drop zero distance, zero length and out-of-history tokens; clamp the length.
   always_comb begin
      verdict.drop = (match_distance == '0) || (match_length == '0) || too_far;
      verdict.len  = too_long ? LEN_W'(MAX_LEN) : match_length;
   end

endmodule

FILE: hdl/lz77_token_decoder.sv
// Top level of the LZ77 token decoder: token sequencer, history pointers and counters.
// Depends on ltd_pkg, ltd_hist_ram and ltd_token_check.

// Each token is accepted when req_ready is high and the block then works on it alone.
// A literal emits its one byte. A match of length L (clamped to MAX_LEN) emits L bytes,
// one byte per cycle while rsp_ready stays high, from the history memory's single read
// port, with a just-written byte forwarded when the distance is one. A dropped match
// (zero length, zero distance, or a distance beyond the bytes written so far) produces
// nothing and leaves the block ready for the next token. The last byte of each token
// carries rsp_last_of_token. No clearing pass runs after reset: the byte count bounds
// every read.
module lz77_token_decoder
   import ltd_pkg::*;
#(
   parameter int WINDOW  = 4096,
   parameter int MAX_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_match,
   input  logic [BYTE_W-1:0] req_literal_byte,
   input  logic [LEN_W-1:0]  req_match_length,
   input  logic [DIST_W-1:0] req_match_distance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_of_token
);

   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  src_ff, src_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              hold_ff, hold_in;
   logic              dist_one_ff, dist_one_in;

   logic              req_xfer;
   logic              rsp_xfer;
   logic [BYTE_W-1:0] cur_byte;
   logic [BYTE_W-1:0] rd_data;
   logic [SUM_W-1:0]  src_sum;
   logic [PTR_W-1:0]  src_start;
   logic [PTR_W-1:0]  src_next;
   logic [PTR_W-1:0]  wp_next;
   tok_chk_type       chk;

   // Match token verdict against the current history fill.
   ltd_token_check #(
      .MAX_LEN (MAX_LEN),
      .CNT_W   (CNT_W)
   ) u_check (
      .match_length   (req_match_length),
      .match_distance (req_match_distance),
      .bytes_written  (cnt_ff),
      .verdict        (chk)
   );

   // History memory; the read address is the next source pointer, so data lines up.
   ltd_hist_ram #(
      .DEPTH (WINDOW),
      .AW    (PTR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (rsp_xfer),
      .wr_addr    (wp_ff),
      .wr_data    (cur_byte),
      .rd_addr    (src_in),
      .rd_data_ff (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // Held byte covers literals and the distance-one overlap; otherwise the memory supplies it.
   assign cur_byte          = hold_ff ? byte_ff : rd_data;
   assign rsp_out_byte      = cur_byte;
   assign rsp_last_of_token = (rem_ff == LEN_W'(1));

   // Start of the copy: write pointer minus distance, modulo the window.
   assign src_sum   = SUM_W'(wp_ff) + SUM_W'(WINDOW) - SUM_W'(req_match_distance);
   assign src_start = (src_sum >= SUM_W'(WINDOW)) ? PTR_W'(src_sum - SUM_W'(WINDOW))
                                                  : PTR_W'(src_sum);
   assign src_next  = (src_ff == PTR_W'(WINDOW - 1)) ? '0 : src_ff + 1'b1;
   assign wp_next   = (wp_ff == PTR_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;

   // Sequencer next-state logic.
   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      src_in      = src_ff;
      rem_in      = rem_ff;
      byte_in     = byte_ff;
      hold_in     = hold_ff;
      dist_one_in = dist_one_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!req_is_match) begin
                  byte_in     = req_literal_byte;
                  hold_in     = 1'b1;
                  rem_in      = LEN_W'(1);
                  dist_one_in = 1'b0;
                  state_in    = ST_EMIT;
               end else if (!chk.drop) begin
                  src_in      = src_start;
                  rem_in      = chk.len;
                  hold_in     = 1'b0;
                  dist_one_in = (req_match_distance == DIST_W'(1));
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               wp_in   = wp_next;
               src_in  = src_next;
               byte_in = cur_byte;
               hold_in = dist_one_ff;
               rem_in  = rem_ff - 1'b1;
               if (cnt_ff != CNT_W'(WINDOW)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (rsp_last_of_token) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         cnt_ff      <= '0;
         rem_ff      <= '0;
         hold_ff     <= 1'b0;
         dist_one_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         cnt_ff      <= cnt_in;
         rem_ff      <= rem_in;
         hold_ff     <= hold_in;
         dist_one_ff <= dist_one_in;
      end
      src_ff  <= src_in;
      byte_ff <= byte_in;
   end

   // The byte count never passes the window size.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("history byte count exceeds window");

   // A dropped match produces no output.
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_is_match && chk.drop) |=> !rsp_valid)
      else $error("dropped match produced output");

   // Transfer of the last byte returns the block to taking tokens.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last_of_token) |=> req_ready)
      else $error("block not ready after last byte");

   // An output transfer writes history and advances the count unless it is saturated.
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && cnt_ff != CNT_W'(WINDOW)) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("byte count did not advance on output");

endmodule
